// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified property checks for the stick shaping core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/rsdz_pkg.sv
// ----------------------------------------------------------------------------
// Radial dead zone package
// Stage map, configuration codes and the per-step arithmetic helpers.
// ----------------------------------------------------------------------------
package rsdz_pkg;

    localparam int SQRT_STEPS = 16;
    localparam int DIV_STEPS  = 15;

    localparam int ST_IN  = 0;
    localparam int ST_SQ  = 1;
    localparam int ST_SUM = 2;
    localparam int ST_RT0 = 3;
    localparam int ST_RTN = ST_RT0 + SQRT_STEPS - 1;
    localparam int ST_SCL = ST_RTN + 1;
    localparam int ST_PRD = ST_SCL + 1;
    localparam int ST_SAT = ST_PRD + 1;
    localparam int ST_DV0 = ST_SAT + 1;
    localparam int ST_DVN = ST_DV0 + DIV_STEPS - 1;
    localparam int ST_OUT = ST_DVN + 1;
    localparam int NS     = ST_OUT + 1;

    localparam logic [0:0] CFG_DEAD = 1'b0;
    localparam logic [0:0] CFG_FULL = 1'b1;

    localparam logic [15:0] DEAD_RESET = 16'd7849;
    localparam logic [15:0] FULL_RESET = 16'd32767;
    localparam logic [15:0] Q_MAX      = 16'd32767;

    typedef struct packed {
        logic [NS-1:0] load;
        logic          out_valid;
    } rsdz_ctrl_t;

    typedef struct packed {
        logic [17:0] rem;
        logic [15:0] root;
        logic [31:0] n;
    } sqrt_st_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [14:0] q;
    } div_st_t;

    function automatic sqrt_st_t sqrt_step(input sqrt_st_t s);
        sqrt_st_t    r;
        logic [19:0] rs;
        logic [19:0] t;
        rs = {s.rem, s.n[31:30]};
        t  = {2'b00, s.root, 2'b01};
        if (rs >= t) begin
            r.rem  = 18'(rs - t);
            r.root = {s.root[14:0], 1'b1};
        end
        else begin
            r.rem  = rs[17:0];
            r.root = {s.root[14:0], 1'b0};
        end
        r.n = {s.n[29:0], 2'b00};
        return r;
    endfunction

    function automatic div_st_t div_step(input div_st_t s, input logic [31:0] den);
        div_st_t     r;
        logic [32:0] r2;
        r2 = {s.rem, 1'b0};
        if (r2 >= {1'b0, den}) begin
            r.rem = 32'(r2 - {1'b0, den});
            r.q   = {s.q[13:0], 1'b1};
        end
        else begin
            r.rem = r2[31:0];
            r.q   = {s.q[13:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// File: rtl/core/rsdz_ctrl.sv
// ----------------------------------------------------------------------------
// Radial dead zone pipeline control
// Per-stage occupancy and load enables; a stage fills whenever it is
// empty or its contents move on.
// ----------------------------------------------------------------------------
module rsdz_ctrl
    import rsdz_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       out_ready,
    output logic       in_ready,
    output rsdz_ctrl_t ctrl
);

    logic [NS-1:0] v_reg;
    logic [NS-1:0] load;

    always_comb
    begin
        load[NS-1] = !v_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            load[i] = !v_reg[i] || load[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (load[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign in_ready       = load[0];
    assign ctrl.load      = load;
    assign ctrl.out_valid = v_reg[NS-1];

endmodule

// File: rtl/core/rsdz_lane.sv
// ----------------------------------------------------------------------------
// Radial dead zone lane
// One stick: magnitude by pipelined square root, scale, pipelined
// division of both components, sign and saturation.
// ----------------------------------------------------------------------------
module rsdz_lane
    import rsdz_pkg::*;
(
    input  logic               clk,
    input  logic [NS-1:0]      load,
    input  logic signed [15:0] raw_x,
    input  logic signed [15:0] raw_y,
    input  logic [15:0]        dead,
    input  logic [15:0]        full,
    output logic signed [15:0] shaped_x,
    output logic signed [15:0] shaped_y
);

    logic        sx_reg  [NS];
    logic        sy_reg  [NS];
    logic [16:0] ax_reg  [NS];
    logic [16:0] ay_reg  [NS];
    logic [30:0] sqx_reg [NS];
    logic [30:0] sqy_reg [NS];
    sqrt_st_t    rt_reg  [NS];
    logic        dz_reg  [NS];
    logic [15:0] num_reg [NS];
    logic [31:0] den_reg [NS];
    logic [31:0] px_reg  [NS];
    logic [31:0] py_reg  [NS];
    logic        satx_reg[NS];
    logic        saty_reg[NS];
    div_st_t     dx_reg  [NS];
    div_st_t     dy_reg  [NS];
    logic signed [15:0] ox_reg;
    logic signed [15:0] oy_reg;

    logic [15:0] mag;
    logic [15:0] m_clamp;
    logic [15:0] q16x;
    logic [15:0] q16y;

    assign mag     = rt_reg[ST_RTN].root;
    assign m_clamp = (mag < full) ? mag : full;
    assign q16x    = satx_reg[ST_DVN] ? Q_MAX : {1'b0, dx_reg[ST_DVN].q};
    assign q16y    = saty_reg[ST_DVN] ? Q_MAX : {1'b0, dy_reg[ST_DVN].q};

    always_ff @(posedge clk)
    begin
        if (load[ST_IN])
        begin
            sx_reg[ST_IN] <= raw_x[15];
            sy_reg[ST_IN] <= (raw_y != 16'sd0) && !raw_y[15];
            ax_reg[ST_IN] <= raw_x[15] ? (17'd0 - {1'b1, raw_x}) : {1'b0, raw_x};
            ay_reg[ST_IN] <= raw_y[15] ? (17'd0 - {1'b1, raw_y}) : {1'b0, raw_y};
        end
    end

    for (genvar i = 1; i < NS; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (load[i])
            begin
                sx_reg[i]   <= sx_reg[i-1];
                sy_reg[i]   <= sy_reg[i-1];
                ax_reg[i]   <= ax_reg[i-1];
                ay_reg[i]   <= ay_reg[i-1];
                sqx_reg[i]  <= sqx_reg[i-1];
                sqy_reg[i]  <= sqy_reg[i-1];
                rt_reg[i]   <= rt_reg[i-1];
                dz_reg[i]   <= dz_reg[i-1];
                num_reg[i]  <= num_reg[i-1];
                den_reg[i]  <= den_reg[i-1];
                px_reg[i]   <= px_reg[i-1];
                py_reg[i]   <= py_reg[i-1];
                satx_reg[i] <= satx_reg[i-1];
                saty_reg[i] <= saty_reg[i-1];
                dx_reg[i]   <= dx_reg[i-1];
                dy_reg[i]   <= dy_reg[i-1];
                if (i == ST_SQ)
                begin
                    sqx_reg[i] <= 31'(ax_reg[i-1] * ax_reg[i-1]);
                    sqy_reg[i] <= 31'(ay_reg[i-1] * ay_reg[i-1]);
                end
                if (i == ST_SUM)
                begin
                    rt_reg[i].rem  <= '0;
                    rt_reg[i].root <= '0;
                    rt_reg[i].n    <= {1'b0, sqx_reg[i-1]} + {1'b0, sqy_reg[i-1]};
                end
                if (i >= ST_RT0 && i <= ST_RTN)
                begin
                    rt_reg[i] <= sqrt_step(rt_reg[i-1]);
                end
                if (i == ST_SCL)
                begin
                    dz_reg[i] <= mag <= dead;
                    if (full <= dead)
                    begin
                        num_reg[i] <= 16'd1;
                        den_reg[i] <= {16'd0, mag};
                    end
                    else
                    begin
                        num_reg[i] <= m_clamp - dead;
                        den_reg[i] <= mag * (full - dead);
                    end
                end
                if (i == ST_PRD)
                begin
                    px_reg[i] <= 32'(ax_reg[i-1] * num_reg[i-1]);
                    py_reg[i] <= 32'(ay_reg[i-1] * num_reg[i-1]);
                end
                if (i == ST_SAT)
                begin
                    satx_reg[i]   <= px_reg[i-1] >= den_reg[i-1];
                    saty_reg[i]   <= py_reg[i-1] >= den_reg[i-1];
                    dx_reg[i].rem <= px_reg[i-1];
                    dx_reg[i].q   <= '0;
                    dy_reg[i].rem <= py_reg[i-1];
                    dy_reg[i].q   <= '0;
                end
                if (i >= ST_DV0 && i <= ST_DVN)
                begin
                    dx_reg[i] <= div_step(dx_reg[i-1], den_reg[i-1]);
                    dy_reg[i] <= div_step(dy_reg[i-1], den_reg[i-1]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[ST_OUT])
        begin
            if (dz_reg[ST_DVN])
            begin
                ox_reg <= '0;
                oy_reg <= '0;
            end
            else
            begin
                ox_reg <= sx_reg[ST_DVN] ? (16'd0 - q16x) : q16x;
                oy_reg <= sy_reg[ST_DVN] ? (16'd0 - q16y) : q16y;
            end
        end
    end

    assign shaped_x = ox_reg;
    assign shaped_y = oy_reg;

endmodule

// File: rtl/core/radial_stick_dead_zone.sv
// ----------------------------------------------------------------------------
// Radial stick dead zone
// Throughput: one word per cycle while out_ready does not stall the output,
// set by the fully pipelined square root (16 stages) and component
// division (15 stages) in each stick lane.
// Reset clears pipeline occupancy and loads the default radii.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module radial_stick_dead_zone
    import rsdz_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] left_x,
    input  logic signed [15:0] left_y,
    input  logic signed [15:0] right_x,
    input  logic signed [15:0] right_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] left_out_x,
    output logic signed [15:0] left_out_y,
    output logic signed [15:0] right_out_x,
    output logic signed [15:0] right_out_y
);

    logic [15:0] dead_reg;
    logic [15:0] full_reg;
    rsdz_ctrl_t  ctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_reg <= DEAD_RESET;
            full_reg <= FULL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEAD: dead_reg <= cfg_data;
                CFG_FULL: full_reg <= cfg_data;
                default:  dead_reg <= dead_reg;
            endcase
        end
    end

    rsdz_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .ctrl      (ctrl)
    );

    rsdz_lane u_left (
        .clk      (clk),
        .load     (ctrl.load),
        .raw_x    (left_x),
        .raw_y    (left_y),
        .dead     (dead_reg),
        .full     (full_reg),
        .shaped_x (left_out_x),
        .shaped_y (left_out_y)
    );

    rsdz_lane u_right (
        .clk      (clk),
        .load     (ctrl.load),
        .raw_x    (right_x),
        .raw_y    (right_y),
        .dead     (dead_reg),
        .full     (full_reg),
        .shaped_x (right_out_x),
        .shaped_y (right_out_y)
    );

    assign out_valid = ctrl.out_valid;

    `ASSERT_IMPLY(a_empty_out_ready, !out_valid, in_ready)
    `ASSERT_IMPLY(a_left_x_range, out_valid, left_out_x != 16'sh8000)
    `ASSERT_IMPLY(a_right_y_range, out_valid, right_out_y != 16'sh8000)
    `ASSERT_ALWAYS(a_ready_follows, in_ready == (ctrl.load[0]))

endmodule

// File: bench/radial_stick_dead_zone_tb.sv
// ----------------------------------------------------------------------------
// Radial stick dead zone testbench
// Drives raw stick words through valid/ready with random gaps and a long
// output hold-off, predicts every shaped word in integer arithmetic, and
// checks the outputs in order across several dead-zone and full-scale
// radius settings, reset values and extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module radial_stick_dead_zone_tb;
    import rsdz_pkg::*;

    typedef struct packed {
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
    } stick_word_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [0:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] left_out_x;
    logic signed [15:0] left_out_y;
    logic signed [15:0] right_out_x;
    logic signed [15:0] right_out_y;

    stick_word_t raw_pending[$];
    stick_word_t shaped_expected[$];
    logic [15:0] dead_radius;
    logic [15:0] full_radius;
    int          mismatches;
    int          in_gap;
    int          out_gap;
    int          hold_left;
    bit          no_idle;
    bit          in_taken;
    bit          out_taken;

    radial_stick_dead_zone dut (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint floor_root(input longint n);
        longint r;
        r = 0;
        for (int b = 16; b >= 0; b--)
        begin
            if ((r | (64'sd1 << b)) * (r | (64'sd1 << b)) <= n)
                r = r | (64'sd1 << b);
        end
        return r;
    endfunction

    function automatic logic [15:0] scale_axis(input longint c, input longint num,
                                               input longint den);
        longint q;
        q = ((c < 0 ? -c : c) * 32768 * num) / den;
        if (q > 32767)
            q = 32767;
        return (c < 0) ? 16'(-q) : 16'(q);
    endfunction

    function automatic logic [31:0] shape_stick(input logic signed [15:0] sx,
                                                input logic signed [15:0] sy);
        longint x;
        longint y;
        longint mag;
        longint num;
        longint den;
        x = sx;
        y = -longint'(sy);
        mag = floor_root(x * x + y * y);
        if (mag <= dead_radius)
            return 32'd0;
        if (full_radius <= dead_radius)
        begin
            num = 1;
            den = mag;
        end
        else
        begin
            num = ((mag < full_radius) ? mag : longint'(full_radius)) - dead_radius;
            den = mag * (full_radius - dead_radius);
        end
        return {scale_axis(x, num, den), scale_axis(y, num, den)};
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 19);
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s expected %0d actual %0d", name, $signed(exp_v), $signed(act_v));
            mismatches++;
        end
    endtask

    // accept and compare at the rising edge
    always @(posedge clk)
    begin
        stick_word_t e;
        in_taken = 1'b0;
        out_taken = 1'b0;
        if (rst_n && in_valid && in_ready)
        begin
            in_taken = 1'b1;
            e = {shape_stick(left_x, left_y), shape_stick(right_x, right_y)};
            shaped_expected.push_back(e);
        end
        if (rst_n && out_valid && out_ready)
        begin
            out_taken = 1'b1;
            if (shaped_expected.size() == 0)
            begin
                $error("output word with nothing expected");
                mismatches++;
            end
            else
            begin
                e = shaped_expected.pop_front();
                check_field("left_out_x", e.lx, left_out_x);
                check_field("left_out_y", e.ly, left_out_y);
                check_field("right_out_x", e.rx, right_out_x);
                check_field("right_out_y", e.ry, right_out_y);
            end
        end
    end

    // driver
    always @(negedge clk)
    begin
        stick_word_t w;
        logic v;
        if (rst_n)
        begin
            v = in_valid;
            if (!in_valid || in_taken)
            begin
                v = 1'b0;
                if (in_gap > 0)
                    in_gap--;
                else if (raw_pending.size() > 0)
                begin
                    w = raw_pending.pop_front();
                    {left_x, left_y, right_x, right_y} <= w;
                    v = 1'b1;
                    in_gap = draw_gap();
                end
            end
            in_valid <= v;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
                out_gap = draw_gap();
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic wait_idle();
        while (raw_pending.size() > 0 || in_valid || shaped_expected.size() > 0)
            @(negedge clk);
        repeat (45) @(negedge clk);
    endtask

    task automatic write_radius(input logic [0:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_DEAD)
            dead_radius = val;
        else
            full_radius = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_axis(input int near);
        int m;
        if (near == 0)
            return 16'($urandom);
        m = $urandom_range(0, near);
        return $urandom_range(0, 1) ? 16'(m) : 16'(-m);
    endfunction

    task automatic queue_random(input int count);
        stick_word_t w;
        int near;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 3))
                0: near = 0;
                1: near = dead_radius + 64;
                2: near = (full_radius > 32767) ? 32767 : full_radius + 64;
                default: near = $urandom_range(1, 32767);
            endcase
            if (near > 32767)
                near = 32767;
            w = {rand_axis(near), rand_axis(near), rand_axis(near), rand_axis(near)};
            raw_pending.push_back(w);
        end
    endtask

    initial
    begin
        logic [15:0] dz [8];
        logic [15:0] fs [8];
        mismatches = 0;
        in_gap = 0;
        out_gap = 0;
        hold_left = 0;
        no_idle = 1'b0;
        in_taken = 1'b0;
        out_taken = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_DEAD;
        cfg_data = '0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        {left_x, left_y, right_x, right_y} = '0;
        dead_radius = DEAD_RESET;
        full_radius = FULL_RESET;
        dz = '{16'd7849, 16'd0, 16'd46340, 16'd1000, 16'd0, 16'd20000, 16'd100, 16'd0};
        fs = '{16'd32767, 16'd46341, 16'd1, 16'd1000, 16'd1, 16'd30000, 16'd46341,
               16'd32768};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        raw_pending.push_back('0);
        raw_pending.push_back({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        raw_pending.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000});
        raw_pending.push_back({16'sh8000, 16'sh0000, 16'sh0000, 16'sh8000});
        raw_pending.push_back({16'sh7fff, 16'sh0000, 16'sh0000, 16'sh7fff});
        raw_pending.push_back({16'sd7849, 16'sd0, 16'sd7850, 16'sd0});
        raw_pending.push_back({16'sd0, -16'sd7849, 16'sd0, -16'sd7850});
        raw_pending.push_back({16'sd5550, 16'sd5550, -16'sd5551, 16'sd5551});
        raw_pending.push_back({16'sd23170, 16'sd23170, -16'sd23171, -16'sd23171});
        raw_pending.push_back({16'sd32767, 16'sd1, 16'sd1, -16'sd32768});
        raw_pending.push_back({16'shffff, 16'sh5555, 16'shaaaa, 16'sh0001});
        raw_pending.push_back({16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa});
        queue_random(230);

        for (int p = 0; p < 8; p++)
        begin
            if (p > 0)
            begin
                wait_idle();
                write_radius(CFG_DEAD, dz[p]);
                write_radius(CFG_FULL, fs[p]);
                no_idle = (p % 3 == 1);
                queue_random(235);
            end
            if (p == 2)
            begin
                repeat (5) @(negedge clk);
                hold_left = 1000;
            end
        end
        wait_idle();
        if (mismatches == 0 && shaped_expected.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/rsdz_pkg.sv
rtl/core/rsdz_ctrl.sv
rtl/core/rsdz_lane.sv
rtl/core/radial_stick_dead_zone.sv
bench/radial_stick_dead_zone_tb.sv
